>>> hdl/rvdec_pkg.sv
// rvdec_pkg: opcodes, mnemonic and status codes and the instruction decode function
package rvdec_pkg;

  localparam int TGT_W = 22;
  localparam int IMM_W = 21;

  localparam logic [6:0] OP_R    = 7'b0110011;
  localparam logic [6:0] OP_IALU = 7'b0010011;
  localparam logic [6:0] OP_LOAD = 7'b0000011;
  localparam logic [6:0] OP_S    = 7'b0100011;
  localparam logic [6:0] OP_B    = 7'b1100011;
  localparam logic [6:0] OP_J    = 7'b1101111;
  localparam logic [6:0] OP_JALR = 7'b1100111;
  localparam logic [6:0] OP_U    = 7'b0110111;

  localparam logic [6:0] F7_ZERO = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SR   = 3'd5;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FUNCT  = 2'd1;
  localparam logic [1:0] ST_BAD_OPCODE = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  localparam logic [2:0] FMT_R = 3'd0;
  localparam logic [2:0] FMT_I = 3'd1;
  localparam logic [2:0] FMT_S = 3'd2;
  localparam logic [2:0] FMT_B = 3'd3;
  localparam logic [2:0] FMT_U = 3'd4;
  localparam logic [2:0] FMT_J = 3'd5;

  localparam logic [5:0] MN_ADD   = 6'd0;
  localparam logic [5:0] MN_SUB   = 6'd1;
  localparam logic [5:0] MN_XOR   = 6'd2;
  localparam logic [5:0] MN_OR    = 6'd3;
  localparam logic [5:0] MN_AND   = 6'd4;
  localparam logic [5:0] MN_SLL   = 6'd5;
  localparam logic [5:0] MN_SRL   = 6'd6;
  localparam logic [5:0] MN_SRA   = 6'd7;
  localparam logic [5:0] MN_SLT   = 6'd8;
  localparam logic [5:0] MN_SLTU  = 6'd9;
  localparam logic [5:0] MN_ADDI  = 6'd10;
  localparam logic [5:0] MN_XORI  = 6'd11;
  localparam logic [5:0] MN_ORI   = 6'd12;
  localparam logic [5:0] MN_ANDI  = 6'd13;
  localparam logic [5:0] MN_SLLI  = 6'd14;
  localparam logic [5:0] MN_SRAI  = 6'd15;
  localparam logic [5:0] MN_SRLI  = 6'd16;
  localparam logic [5:0] MN_SLTI  = 6'd17;
  localparam logic [5:0] MN_SLTIU = 6'd18;
  localparam logic [5:0] MN_LB    = 6'd19;
  localparam logic [5:0] MN_LH    = 6'd20;
  localparam logic [5:0] MN_LW    = 6'd21;
  localparam logic [5:0] MN_LD    = 6'd22;
  localparam logic [5:0] MN_LBU   = 6'd23;
  localparam logic [5:0] MN_LHU   = 6'd24;
  localparam logic [5:0] MN_LWU   = 6'd25;
  localparam logic [5:0] MN_JALR  = 6'd26;
  localparam logic [5:0] MN_SB    = 6'd27;
  localparam logic [5:0] MN_SH    = 6'd28;
  localparam logic [5:0] MN_SW    = 6'd29;
  localparam logic [5:0] MN_SD    = 6'd30;
  localparam logic [5:0] MN_BEQ   = 6'd31;
  localparam logic [5:0] MN_BNE   = 6'd32;
  localparam logic [5:0] MN_BLT   = 6'd33;
  localparam logic [5:0] MN_BGE   = 6'd34;
  localparam logic [5:0] MN_BLTU  = 6'd35;
  localparam logic [5:0] MN_BGEU  = 6'd36;
  localparam logic [5:0] MN_LUI   = 6'd37;
  localparam logic [5:0] MN_JAL   = 6'd38;
  localparam logic [5:0] MN_NONE  = 6'h3F;

  // funct3 lookup tables, MN_NONE marks an invalid code
  localparam logic [5:0] R_F3_MN [8] = '{MN_ADD, MN_SLL, MN_SLT, MN_SLTU,
                                         MN_XOR, MN_SRL, MN_OR, MN_AND};
  localparam logic [5:0] I_F3_MN [8] = '{MN_ADDI, MN_SLLI, MN_SLTI, MN_SLTIU,
                                         MN_XORI, MN_NONE, MN_ORI, MN_ANDI};
  localparam logic [5:0] LD_F3_MN [8] = '{MN_LB, MN_LH, MN_LW, MN_LD,
                                          MN_LBU, MN_LHU, MN_LWU, MN_NONE};
  localparam logic [5:0] ST_F3_MN [8] = '{MN_SB, MN_SH, MN_SW, MN_SD,
                                          MN_NONE, MN_NONE, MN_NONE, MN_NONE};
  localparam logic [5:0] BR_F3_MN [8] = '{MN_BEQ, MN_BNE, MN_NONE, MN_NONE,
                                          MN_BLT, MN_BGE, MN_BLTU, MN_BGEU};

  typedef struct packed {
    logic [1:0]              status;
    logic [2:0]              fmt;
    logic [5:0]              mn;
    logic [4:0]              dst;
    logic [4:0]              src1;
    logic [4:0]              src2;
    logic signed [IMM_W-1:0] imm;
    logic                    jump;
  } dec_t;

  function automatic dec_t decode(input logic [31:0] w);
    dec_t       d;
    logic [6:0] op;
    logic [2:0] f3;
    logic [6:0] f7;
    logic       known;
    d     = '0;
    op    = w[6:0];
    f3    = w[14:12];
    f7    = w[31:25];
    known = 1'b1;
    d.mn  = MN_NONE;
    case (op)
      OP_R: begin
        d.fmt  = FMT_R;
        d.dst  = w[11:7];
        d.src1 = w[19:15];
        d.src2 = w[24:20];
        if (f7 == F7_ZERO) d.mn = R_F3_MN[f3];
        else if (f7 == F7_ALT && f3 == F3_ADD) d.mn = MN_SUB;
        else if (f7 == F7_ALT && f3 == F3_SR) d.mn = MN_SRA;
      end
      OP_IALU, OP_LOAD, OP_JALR: begin
        d.fmt  = FMT_I;
        d.dst  = w[11:7];
        d.src1 = w[19:15];
        d.imm  = IMM_W'($signed(w[31:20]));
        if (op == OP_JALR) d.mn = MN_JALR;
        else if (op == OP_LOAD) d.mn = LD_F3_MN[f3];
        else if (f3 == F3_SR) begin
          // immediate bit 10 picks srai, which reports only the low ten bits
          if (w[30]) begin
            d.mn  = MN_SRAI;
            d.imm = IMM_W'(w[29:20]);
          end else begin
            d.mn = MN_SRLI;
          end
        end else begin
          d.mn = I_F3_MN[f3];
        end
      end
      OP_S: begin
        d.fmt  = FMT_S;
        d.src1 = w[19:15];
        d.src2 = w[24:20];
        d.imm  = IMM_W'($signed({w[31:25], w[11:7]}));
        d.mn   = ST_F3_MN[f3];
      end
      OP_B: begin
        d.fmt  = FMT_B;
        d.src1 = w[19:15];
        d.src2 = w[24:20];
        d.imm  = IMM_W'($signed({w[31], w[7], w[30:25], w[11:8], 1'b0}));
        d.mn   = BR_F3_MN[f3];
        d.jump = 1'b1;
      end
      OP_U: begin
        d.fmt = FMT_U;
        d.dst = w[11:7];
        d.imm = IMM_W'(w[31:12]);
        d.mn  = MN_LUI;
      end
      OP_J: begin
        d.fmt  = FMT_J;
        d.dst  = w[11:7];
        d.imm  = $signed({w[31], w[19:12], w[20], w[30:21], 1'b0});
        d.mn   = MN_JAL;
        d.jump = 1'b1;
      end
      default: known = 1'b0;
    endcase
    if (!known) begin
      d        = '0;
      d.status = ST_BAD_OPCODE;
    end else if (d.mn == MN_NONE) begin
      d.status = ST_BAD_FUNCT;
      d.mn     = MN_ADD;
      d.jump   = 1'b0;
    end
    return d;
  endfunction

endpackage

>>> hdl/rv64i_decode_with_labels.sv
// rv64i_decode_with_labels: decoder top level with branch-target label table in a memory
// non-branch items: result registered in the cycle after accept, a new item every cycle while not busy
// branch and jal items: label memory scanned one entry per cycle, pipelined through the
//   registered read port; the result follows a match or the end of the scan over all stored labels
// busy is high while a scan runs; done marks each result for one cycle
// rst clears the line counter to 1 and the label count to 0; the label memory is not cleared
module rv64i_decode_with_labels
  import rvdec_pkg::*;
#(
  parameter int LABEL_DEPTH = 256,
  parameter int LINE_BITS   = 20,
  localparam int CNT_W      = $clog2(LABEL_DEPTH + 1),
  localparam int IDX_W      = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [31:0]             instr_word,
  output logic                    done,
  output logic [1:0]              status,
  output logic [2:0]              format,
  output logic [5:0]              mnemonic,
  output logic [4:0]              dest_reg,
  output logic [4:0]              src1_reg,
  output logic [4:0]              src2_reg,
  output logic signed [IMM_W-1:0] immediate,
  output logic signed [TGT_W-1:0] target_line,
  output logic [CNT_W-1:0]        label_number,
  output logic                    label_new
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                 state;
  logic [LINE_BITS-1:0] line_counter;
  logic [CNT_W-1:0]     label_count;
  logic [CNT_W-1:0]     scan_idx;
  logic [CNT_W-1:0]     cmp_idx;
  logic                 cmp_valid;

  logic [TGT_W-1:0] label_mem [LABEL_DEPTH];
  logic [TGT_W-1:0] mem_rdata;
  logic             mem_we;

  dec_t                    dec;
  logic                    accept;
  logic signed [IMM_W-1:0] quot;
  logic [TGT_W-1:0]        tgt_calc;
  logic                    hit;
  logic                    issue;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign dec    = decode(instr_word);

  // offset / 4 rounded toward zero
  assign quot     = (dec.imm + $signed(IMM_W'({dec.imm[IMM_W-1], dec.imm[IMM_W-1]}))) >>> 2;
  assign tgt_calc = TGT_W'(line_counter) + TGT_W'(quot);

  assign hit    = cmp_valid && (mem_rdata == target_line);
  assign issue  = scan_idx < label_count;
  assign mem_we = (state == S_SCAN) && !hit && !issue &&
                  (label_count < CNT_W'(LABEL_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) label_mem[label_count[IDX_W-1:0]] <= target_line;
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && issue) mem_rdata <= label_mem[scan_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      line_counter <= LINE_BITS'(1);
      label_count  <= '0;
      done         <= 1'b0;
      scan_idx     <= '0;
      cmp_valid    <= 1'b0;
    end else begin
      done <= (state == S_IDLE) ? (accept && !dec.jump) : (hit || !issue);
      case (state)
        S_IDLE: begin
          if (accept) begin
            line_counter <= line_counter + LINE_BITS'(1);
            scan_idx     <= '0;
            cmp_valid    <= 1'b0;
            if (dec.jump) state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_valid <= issue;
          cmp_idx   <= scan_idx;
          if (issue) scan_idx <= scan_idx + CNT_W'(1);
          if (hit) begin
            label_number <= cmp_idx + CNT_W'(1);
            state        <= S_IDLE;
          end else if (!issue) begin
            // every stored label compared without a match
            if (label_count < CNT_W'(LABEL_DEPTH)) begin
              label_count  <= label_count + CNT_W'(1);
              label_number <= label_count + CNT_W'(1);
              label_new    <= 1'b1;
            end else begin
              status <= ST_FULL;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    if (accept) begin
      status       <= dec.status;
      format       <= dec.fmt;
      mnemonic     <= dec.mn;
      dest_reg     <= dec.dst;
      src1_reg     <= dec.src1;
      src2_reg     <= dec.src2;
      immediate    <= dec.imm;
      target_line  <= dec.jump ? tgt_calc : '0;
      label_number <= '0;
      label_new    <= 1'b0;
    end
  end

endmodule
